### src/gpf_pkg.sv
// ----------------------------------------------------------------------------
// gpf_pkg
// Shared widths, register indices and constants for the pair force block.
// ----------------------------------------------------------------------------
package gpf_pkg;

  localparam int unsigned DataW   = 32;   // Q16.16 field width
  localparam int unsigned DiffW   = 33;   // exact offset / magnitude of offset
  localparam int unsigned SqW     = 66;   // dx^2 + dy^2, Q32.32
  localparam int unsigned DsqW    = 50;   // sum of squares >> 16
  localparam int unsigned RootW   = 33;   // integer square root of SqW bits
  localparam int unsigned RemSqW  = 35;   // square-root partial remainder
  localparam int unsigned ProdW   = 96;   // G * ma * mb
  localparam int unsigned MagDW   = 48;   // clamped distance << 16
  localparam int unsigned MagW    = 64;   // force magnitude
  localparam int unsigned CompNW  = 97;   // magnitude * |offset|
  localparam int unsigned CompQW  = 32;   // component quotient bits
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegGravConst = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMinDistSq = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxDistSq = 2'd2;

  localparam logic [DataW-1:0] GravConstRst = 32'h0001_0000;
  localparam logic [DataW-1:0] MinDistSqRst = 32'h0001_0000;
  localparam logic [DataW-1:0] MaxDistSqRst = 32'hFFFF_FFFF;

  localparam logic [DataW-1:0] PosSat = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] NegSat = 32'h8000_0000;

endpackage

### src/gpf_sqrt_cell.sv
// ----------------------------------------------------------------------------
// gpf_sqrt_cell
// One registered digit step of a restoring integer square root.
// ----------------------------------------------------------------------------
module gpf_sqrt_cell import gpf_pkg::*; #(
  parameter int unsigned SideW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [SqW-1:0]    in_s,
  input  logic [RemSqW-1:0] in_rem,
  input  logic [RootW-1:0]  in_root,
  input  logic [SideW-1:0]  in_side,
  output logic              out_vld,
  output logic [SqW-1:0]    out_s,
  output logic [RemSqW-1:0] out_rem,
  output logic [RootW-1:0]  out_root,
  output logic [SideW-1:0]  out_side
);

  localparam int unsigned TW = RemSqW + 2;

  logic              vld_r;
  logic [SqW-1:0]    s_r,    s_nxt;
  logic [RemSqW-1:0] rem_r,  rem_nxt;
  logic [RootW-1:0]  root_r, root_nxt;
  logic [SideW-1:0]  side_r;
  logic [TW-1:0]     tmp, trial;
  logic              ge;

  always_comb begin
    tmp      = {in_rem, in_s[SqW-1 -: 2]};
    trial    = TW'({in_root, 2'b01});
    ge       = (tmp >= trial);
    rem_nxt  = ge ? RemSqW'(tmp - trial) : RemSqW'(tmp);
    root_nxt = {in_root[RootW-2:0], ge};
    s_nxt    = {in_s[SqW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r    <= s_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_s    = s_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_side = side_r;

endmodule

### src/gpf_div_cell.sv
// ----------------------------------------------------------------------------
// gpf_div_cell
// One registered step of a restoring divider; quotient shifts into num.
// ----------------------------------------------------------------------------
module gpf_div_cell import gpf_pkg::*; #(
  parameter int unsigned DW    = 32,
  parameter int unsigned NW    = 32,
  parameter int unsigned SideW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [DW-1:0]    in_d,
  input  logic [DW-1:0]    in_rem,
  input  logic [NW-1:0]    in_num,
  input  logic [SideW-1:0] in_side,
  output logic             out_vld,
  output logic [DW-1:0]    out_d,
  output logic [DW-1:0]    out_rem,
  output logic [NW-1:0]    out_num,
  output logic [SideW-1:0] out_side
);

  logic             vld_r;
  logic [DW-1:0]    d_r;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [NW-1:0]    num_r, num_nxt;
  logic [SideW-1:0] side_r;
  logic [DW:0]      t;
  logic             ge;

  always_comb begin
    t       = {in_rem, in_num[NW-1]};
    ge      = (t >= {1'b0, in_d});
    rem_nxt = ge ? DW'(t - {1'b0, in_d}) : DW'(t);
    num_nxt = {in_num[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= in_d;
      rem_r  <= rem_nxt;
      num_r  <= num_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_d    = d_r;
  assign out_rem  = rem_r;
  assign out_num  = num_r;
  assign out_side = side_r;

endmodule

### src/gravitational_pair_force.sv
// ----------------------------------------------------------------------------
// gravitational_pair_force
// Newtonian 2D attraction force on body A from body B, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries the two positions and masses;
//   result channel (out_valid/out_ready) returns force_x, force_y and the
//   saturated flag. Registers (grav_const, min_dist_sq, max_dist_sq) are
//   written over cfg_valid/cfg_ready with cfg_index and cfg_data; the user
//   must write them only while the pipe is empty, which the block does not
//   enforce. cfg_ready is always high and unknown indices are dropped.
//   Throughput: one pair per cycle while the output is not stalled. The pipe
//   holds 136 register stages from the input to the output register - 3 front
//   stages, 33 square-root cells, a clamp stage, 64 magnitude divider cells,
//   2 product stages, 32 component divider cells and the output register.
//   The cell rows make up most of these stages; each cell resolves one root
//   or quotient digit per cycle while the pipe advances and hands its word on.
//   Stall: while a result waits (out_valid high, out_ready low) the whole pipe
//   holds and in_ready is low; transfers resume as soon as it is taken.
//   Reset (rst_n low, synchronous) empties the pipe and loads the register
//   reset values.
// ----------------------------------------------------------------------------
module gravitational_pair_force import gpf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [DataW-1:0]    cfg_data,
  // pair in
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [DataW-1:0] in_pos_a_x,
  input  logic signed [DataW-1:0] in_pos_a_y,
  input  logic signed [DataW-1:0] in_pos_b_x,
  input  logic signed [DataW-1:0] in_pos_b_y,
  input  logic [DataW-1:0]    in_mass_a,
  input  logic [DataW-1:0]    in_mass_b,
  // force out
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [DataW-1:0] out_force_x,
  output logic signed [DataW-1:0] out_force_y,
  output logic                out_saturated
);

  localparam int unsigned SqSideW  = ProdW + DsqW + 2*DiffW + 3;
  localparam int unsigned MagSideW = 1 + RootW + 2*DiffW + 3;
  localparam int unsigned CxSideW  = 3;
  localparam int unsigned CySideW  = 2;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DataW-1:0] grav_const_r, min_dist_sq_r, max_dist_sq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_const_r  <= GravConstRst;
      min_dist_sq_r <= MinDistSqRst;
      max_dist_sq_r <= MaxDistSqRst;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegGravConst: grav_const_r  <= cfg_data;
        RegMinDistSq: min_dist_sq_r <= cfg_data;
        RegMaxDistSq: max_dist_sq_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipe advances unless a finished result is held up
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // Front: offsets, magnitudes, G*ma
  // --------------------------------------------------------------------------
  logic [DiffW-1:0] dx_c, dy_c, ax_c, ay_c;
  logic [MagW-1:0]  gma_c;

  always_comb begin
    dx_c  = DiffW'({in_pos_b_x[DataW-1], in_pos_b_x} - {in_pos_a_x[DataW-1], in_pos_a_x});
    dy_c  = DiffW'({in_pos_b_y[DataW-1], in_pos_b_y} - {in_pos_a_y[DataW-1], in_pos_a_y});
    ax_c  = dx_c[DiffW-1] ? DiffW'(~dx_c + 1'b1) : dx_c;
    ay_c  = dy_c[DiffW-1] ? DiffW'(~dy_c + 1'b1) : dy_c;
    gma_c = grav_const_r * in_mass_a;
  end

  logic             v0_r, v1_r, v2_r;
  logic [DiffW-1:0] ax0_r, ay0_r, ax1_r, ay1_r, ax2_r, ay2_r;
  logic             nx0_r, ny0_r, z0_r, nx1_r, ny1_r, z1_r, nx2_r, ny2_r, z2_r;
  logic [MagW-1:0]  gma0_r;
  logic [DataW-1:0] mb0_r;
  logic [SqW-1:0]   sqx1_r, sqy1_r, s2_r;
  logic [MagW-1:0]  pl1_r, ph1_r;
  logic [ProdW-1:0] p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 0
      ax0_r  <= ax_c;
      ay0_r  <= ay_c;
      nx0_r  <= dx_c[DiffW-1];
      ny0_r  <= dy_c[DiffW-1];
      z0_r   <= (dx_c == '0) && (dy_c == '0);
      gma0_r <= gma_c;
      mb0_r  <= in_mass_b;
      // stage 1: squares and split G*ma*mb partial products
      sqx1_r <= ax0_r * ax0_r;
      sqy1_r <= ay0_r * ay0_r;
      pl1_r  <= gma0_r[DataW-1:0] * mb0_r;
      ph1_r  <= gma0_r[MagW-1:DataW] * mb0_r;
      ax1_r  <= ax0_r;
      ay1_r  <= ay0_r;
      nx1_r  <= nx0_r;
      ny1_r  <= ny0_r;
      z1_r   <= z0_r;
      // stage 2: sums
      s2_r   <= sqx1_r + sqy1_r;
      p2_r   <= {ph1_r, {DataW{1'b0}}} + ProdW'(pl1_r);
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      nx2_r  <= nx1_r;
      ny2_r  <= ny1_r;
      z2_r   <= z1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Square-root row: len = floor(sqrt(dx^2 + dy^2))
  // --------------------------------------------------------------------------
  logic              sq_vld  [0:RootW];
  logic [SqW-1:0]    sq_s    [0:RootW];
  logic [RemSqW-1:0] sq_rem  [0:RootW];
  logic [RootW-1:0]  sq_root [0:RootW];
  logic [SqSideW-1:0] sq_side [0:RootW];

  assign sq_vld[0]  = v2_r;
  assign sq_s[0]    = s2_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {p2_r, s2_r[SqW-1:SqW-DsqW], ax2_r, ay2_r, nx2_r, ny2_r, z2_r};

  for (genvar i = 0; i < RootW; i++) begin : g_sqrt
    gpf_sqrt_cell #(.SideW(SqSideW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_vld   (sq_vld[i]),
      .in_s     (sq_s[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_side  (sq_side[i]),
      .out_vld  (sq_vld[i+1]),
      .out_s    (sq_s[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_side (sq_side[i+1])
    );
  end

  logic [ProdW-1:0] sq_p;
  logic [DsqW-1:0]  sq_dsq;
  logic [DiffW-1:0] sq_ax, sq_ay;
  logic             sq_nx, sq_ny, sq_z;
  assign {sq_p, sq_dsq, sq_ax, sq_ay, sq_nx, sq_ny, sq_z} = sq_side[RootW];

  // --------------------------------------------------------------------------
  // Clamp stage (upper bound first, then lower, never zero)
  // --------------------------------------------------------------------------
  logic [DataW-1:0] c_hi, c_lo, c_c;
  always_comb begin
    c_hi = (sq_dsq < DsqW'(max_dist_sq_r)) ? sq_dsq[DataW-1:0] : max_dist_sq_r;
    c_lo = (c_hi < min_dist_sq_r) ? min_dist_sq_r : c_hi;
    c_c  = (c_lo == '0) ? DataW'(1) : c_lo;
  end

  logic             v3_r;
  logic [DataW-1:0] c3_r;
  logic [RootW-1:0] len3_r;
  logic [ProdW-1:0] p3_r;
  logic [DiffW-1:0] ax3_r, ay3_r;
  logic             nx3_r, ny3_r, z3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= sq_vld[RootW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3_r   <= c_c;
      len3_r <= sq_root[RootW];
      p3_r   <= sq_p;
      ax3_r  <= sq_ax;
      ay3_r  <= sq_ay;
      nx3_r  <= sq_nx;
      ny3_r  <= sq_ny;
      z3_r   <= sq_z;
    end
  end

  // --------------------------------------------------------------------------
  // Magnitude divider row: mag = G*ma*mb / (c << 16), held to 64 bits
  // --------------------------------------------------------------------------
  logic [MagDW-1:0] md_d0;
  logic             md_ovf0;
  assign md_d0   = {c3_r, 16'h0000};
  assign md_ovf0 = (MagDW'(p3_r[ProdW-1:MagW]) >= md_d0);

  logic               md_vld  [0:MagW];
  logic [MagDW-1:0]   md_d    [0:MagW];
  logic [MagDW-1:0]   md_rem  [0:MagW];
  logic [MagW-1:0]    md_num  [0:MagW];
  logic [MagSideW-1:0] md_side [0:MagW];

  assign md_vld[0]  = v3_r;
  assign md_d[0]    = md_d0;
  assign md_rem[0]  = MagDW'(p3_r[ProdW-1:MagW]);
  assign md_num[0]  = p3_r[MagW-1:0];
  assign md_side[0] = {md_ovf0, len3_r, ax3_r, ay3_r, nx3_r, ny3_r, z3_r};

  for (genvar i = 0; i < MagW; i++) begin : g_mag
    gpf_div_cell #(.DW(MagDW), .NW(MagW), .SideW(MagSideW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_vld   (md_vld[i]),
      .in_d     (md_d[i]),
      .in_rem   (md_rem[i]),
      .in_num   (md_num[i]),
      .in_side  (md_side[i]),
      .out_vld  (md_vld[i+1]),
      .out_d    (md_d[i+1]),
      .out_rem  (md_rem[i+1]),
      .out_num  (md_num[i+1]),
      .out_side (md_side[i+1])
    );
  end

  logic             md_ovf;
  logic [RootW-1:0] md_len;
  logic [DiffW-1:0] md_ax, md_ay;
  logic             md_nx, md_ny, md_z;
  logic [MagW-1:0]  mag_c;
  assign {md_ovf, md_len, md_ax, md_ay, md_nx, md_ny, md_z} = md_side[MagW];
  assign mag_c = md_ovf ? {MagW{1'b1}} : md_num[MagW];

  // --------------------------------------------------------------------------
  // mag * |d| in split partial products, then sum
  // --------------------------------------------------------------------------
  logic                v5_r, v6_r;
  logic [DataW+DiffW-1:0] mxl5_r, mxh5_r, myl5_r, myh5_r;
  logic [RootW-1:0]    len5_r, len6_r;
  logic                nx5_r, ny5_r, z5_r, nx6_r, ny6_r, z6_r;
  logic [CompNW-1:0]   nx6n_r, ny6n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v5_r <= md_vld[MagW];
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mxl5_r <= mag_c[DataW-1:0] * md_ax;
      mxh5_r <= mag_c[MagW-1:DataW] * md_ax;
      myl5_r <= mag_c[DataW-1:0] * md_ay;
      myh5_r <= mag_c[MagW-1:DataW] * md_ay;
      len5_r <= md_len;
      nx5_r  <= md_nx;
      ny5_r  <= md_ny;
      z5_r   <= md_z;
      nx6n_r <= {mxh5_r, {DataW{1'b0}}} + CompNW'(mxl5_r);
      ny6n_r <= {myh5_r, {DataW{1'b0}}} + CompNW'(myl5_r);
      len6_r <= len5_r;
      nx6_r  <= nx5_r;
      ny6_r  <= ny5_r;
      z6_r   <= z5_r;
    end
  end

  // --------------------------------------------------------------------------
  // Component divider rows: |f| = mag*|d| / len, 32 quotient bits
  // --------------------------------------------------------------------------
  logic cx_ovf0, cy_ovf0;
  assign cx_ovf0 = (nx6n_r[CompNW-1:CompQW] >= (CompNW-CompQW)'(len6_r));
  assign cy_ovf0 = (ny6n_r[CompNW-1:CompQW] >= (CompNW-CompQW)'(len6_r));

  logic               cx_vld  [0:CompQW];
  logic [RootW-1:0]   cx_d    [0:CompQW];
  logic [RootW-1:0]   cx_rem  [0:CompQW];
  logic [CompQW-1:0]  cx_num  [0:CompQW];
  logic [CxSideW-1:0] cx_side [0:CompQW];
  logic               cy_vld  [0:CompQW];
  logic [RootW-1:0]   cy_d    [0:CompQW];
  logic [RootW-1:0]   cy_rem  [0:CompQW];
  logic [CompQW-1:0]  cy_num  [0:CompQW];
  logic [CySideW-1:0] cy_side [0:CompQW];

  assign cx_vld[0]  = v6_r;
  assign cx_d[0]    = len6_r;
  assign cx_rem[0]  = nx6n_r[CompQW+RootW-1:CompQW];
  assign cx_num[0]  = nx6n_r[CompQW-1:0];
  assign cx_side[0] = {cx_ovf0, nx6_r, z6_r};
  assign cy_vld[0]  = v6_r;
  assign cy_d[0]    = len6_r;
  assign cy_rem[0]  = ny6n_r[CompQW+RootW-1:CompQW];
  assign cy_num[0]  = ny6n_r[CompQW-1:0];
  assign cy_side[0] = {cy_ovf0, ny6_r};

  for (genvar i = 0; i < CompQW; i++) begin : g_comp
    gpf_div_cell #(.DW(RootW), .NW(CompQW), .SideW(CxSideW)) u_cell_x (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_vld   (cx_vld[i]),
      .in_d     (cx_d[i]),
      .in_rem   (cx_rem[i]),
      .in_num   (cx_num[i]),
      .in_side  (cx_side[i]),
      .out_vld  (cx_vld[i+1]),
      .out_d    (cx_d[i+1]),
      .out_rem  (cx_rem[i+1]),
      .out_num  (cx_num[i+1]),
      .out_side (cx_side[i+1])
    );
    gpf_div_cell #(.DW(RootW), .NW(CompQW), .SideW(CySideW)) u_cell_y (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_vld   (cy_vld[i]),
      .in_d     (cy_d[i]),
      .in_rem   (cy_rem[i]),
      .in_num   (cy_num[i]),
      .in_side  (cy_side[i]),
      .out_vld  (cy_vld[i+1]),
      .out_d    (cy_d[i+1]),
      .out_rem  (cy_rem[i+1]),
      .out_num  (cy_num[i+1]),
      .out_side (cy_side[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Sign, saturation and output register
  // --------------------------------------------------------------------------
  logic              fx_ovf, fx_neg, f_zero, fy_ovf, fy_neg;
  logic [CompQW-1:0] qx, qy;
  logic [DataW-1:0]  fx_c, fy_c;
  logic              satx_c, saty_c;
  logic              fin_vld;

  assign {fx_ovf, fx_neg, f_zero} = cx_side[CompQW];
  assign {fy_ovf, fy_neg}         = cy_side[CompQW];
  assign qx      = cx_num[CompQW];
  assign qy      = cy_num[CompQW];
  assign fin_vld = cx_vld[CompQW] && cy_vld[CompQW];

  always_comb begin
    fx_c   = '0;
    satx_c = 1'b0;
    if (!fx_neg) begin
      if (fx_ovf || qx > PosSat) begin
        fx_c   = PosSat;
        satx_c = 1'b1;
      end else begin
        fx_c = qx;
      end
    end else if (fx_ovf || qx > NegSat) begin
      fx_c   = NegSat;
      satx_c = 1'b1;
    end else begin
      fx_c = DataW'(~qx + 1'b1);
    end

    fy_c   = '0;
    saty_c = 1'b0;
    if (!fy_neg) begin
      if (fy_ovf || qy > PosSat) begin
        fy_c   = PosSat;
        saty_c = 1'b1;
      end else begin
        fy_c = qy;
      end
    end else if (fy_ovf || qy > NegSat) begin
      fy_c   = NegSat;
      saty_c = 1'b1;
    end else begin
      fy_c = DataW'(~qy + 1'b1);
    end

    // coincident bodies: no force
    if (f_zero) begin
      fx_c   = '0;
      fy_c   = '0;
      satx_c = 1'b0;
      saty_c = 1'b0;
    end
  end

  logic [DataW-1:0] out_force_x_r, out_force_y_r;
  logic             out_saturated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_force_x_r   <= fx_c;
      out_force_y_r   <= fy_c;
      out_saturated_r <= satx_c || saty_c;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_force_x   = out_force_x_r;
  assign out_force_y   = out_force_y_r;
  assign out_saturated = out_saturated_r;

`ifndef SYNTHESIS
  // flag only with a clipped component on show
  a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_saturated_r) |->
      (out_force_x_r == PosSat || out_force_x_r == NegSat ||
       out_force_y_r == PosSat || out_force_y_r == NegSat))
    else $error("saturated flag without a clipped component");

  // coincident bodies give a zero result
  a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && fin_vld && f_zero) |=>
      (out_force_x_r == '0 && out_force_y_r == '0 && !out_saturated_r))
    else $error("zero offset gave nonzero force");

  // x and y divider rows stay in step
  a_rows_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    cx_vld[CompQW] == cy_vld[CompQW])
    else $error("component rows out of step");

  // a finished item reaches the output register
  a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && fin_vld) |=> out_valid_r)
    else $error("finished item lost before output");
`endif

endmodule

### tb/gpf_force_checker.sv
// ----------------------------------------------------------------------------
// gpf_force_checker
// Watches the pair, result and register channels of the pair force block,
// predicts each force from its own copy of the registers and compares.
// ----------------------------------------------------------------------------
module gpf_force_checker import gpf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [DataW-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [DataW-1:0] in_pos_a_x,
  input  logic signed [DataW-1:0] in_pos_a_y,
  input  logic signed [DataW-1:0] in_pos_b_x,
  input  logic signed [DataW-1:0] in_pos_b_y,
  input  logic [DataW-1:0]        in_mass_a,
  input  logic [DataW-1:0]        in_mass_b,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [DataW-1:0] out_force_x,
  input  logic signed [DataW-1:0] out_force_y,
  input  logic                    out_saturated,
  output int                      errors,
  output int                      pending,
  output int                      forces_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DataW-1:0] fx;
    logic signed [DataW-1:0] fy;
    logic                    sat;
  } force_t;

  logic [DataW-1:0] g_reg, dmin_reg, dmax_reg;
  force_t           force_q[$];

  initial begin
    errors      = 0;
    forces_seen = 0;
  end

  assign pending = force_q.size();

  task automatic report(input string what);
    errors++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  // mag * |dc| / len, sign of dc, clipped to 32 bits
  function automatic logic [DataW-1:0] axis_force(input logic [63:0] mag,
                                                  input logic signed [32:0] dc,
                                                  input logic [127:0] len,
                                                  inout logic sat);
    logic [127:0] n, q;
    logic [32:0]  a;
    a = dc[32] ? 33'(-dc) : 33'(dc);
    n = mag;
    n = n * a;
    q = n / len;
    if (!dc[32]) begin
      if (q > 128'h7FFF_FFFF) begin
        sat = 1'b1;
        return PosSat;
      end
      return q[31:0];
    end
    if (q > 128'h8000_0000) begin
      sat = 1'b1;
      return NegSat;
    end
    return 32'(-q[31:0]);
  endfunction

  function automatic force_t pair_force(input logic signed [DataW-1:0] ax,
                                        input logic signed [DataW-1:0] ay,
                                        input logic signed [DataW-1:0] bx,
                                        input logic signed [DataW-1:0] by,
                                        input logic [DataW-1:0] ma,
                                        input logic [DataW-1:0] mb);
    logic signed [32:0] dx, dy;
    logic [32:0]        ux, uy;
    logic [127:0]       s, dsq, c, root, t, p, m;
    logic [63:0]        mag;
    logic               sat;
    force_t             f;
    dx = {bx[31], bx} - {ax[31], ax};
    dy = {by[31], by} - {ay[31], ay};
    ux = dx[32] ? 33'(-dx) : 33'(dx);
    uy = dy[32] ? 33'(-dy) : 33'(dy);
    f = '0;
    if (ux == 0 && uy == 0) return f;   // coincident bodies: no force
    s = ux;
    s = s * ux;
    t = uy;
    s = s + t * uy;
    dsq = s >> 16;
    c = (dsq < dmax_reg) ? dsq : 128'(dmax_reg);
    if (c < dmin_reg) c = dmin_reg;     // lower clamp wins when bounds cross
    if (c == 0) c = 1;
    root = 0;
    for (int i = 33; i >= 0; i--) begin
      t = root | (128'd1 << i);
      if (t * t <= s) root = t;
    end
    p = g_reg;
    p = p * ma;
    p = p * mb;
    m = p / (c << 16);
    mag = (m[127:64] != 0) ? '1 : m[63:0];
    sat = 1'b0;
    f.fx = axis_force(mag, dx, root, sat);
    f.fy = axis_force(mag, dy, root, sat);
    f.sat = sat;
    return f;
  endfunction

  always @(posedge clk) begin
    force_t want;
    if (!rst_n) begin
      g_reg    <= GravConstRst;
      dmin_reg <= MinDistSqRst;
      dmax_reg <= MaxDistSqRst;
      force_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegGravConst: g_reg    <= cfg_data;
          RegMinDistSq: dmin_reg <= cfg_data;
          RegMaxDistSq: dmax_reg <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        force_q.push_back(pair_force(in_pos_a_x, in_pos_a_y, in_pos_b_x, in_pos_b_y,
                                     in_mass_a, in_mass_b));
      if (out_valid && out_ready) begin
        forces_seen++;
        if (force_q.size() == 0) begin
          report("force transfer with nothing expected");
        end else begin
          want = force_q.pop_front();
          if (out_force_x !== want.fx)
            report($sformatf("force_x %h, want %h", out_force_x, want.fx));
          if (out_force_y !== want.fy)
            report($sformatf("force_y %h, want %h", out_force_y, want.fy));
          if (out_saturated !== want.sat)
            report($sformatf("saturated %b, want %b", out_saturated, want.sat));
        end
      end
    end
  end

endmodule

### tb/tb_gravitational_pair_force.sv
// ----------------------------------------------------------------------------
// tb_gravitational_pair_force
// Drives pairs and register writes into the pair force block under several
// register settings and idle patterns; the checker beside it does the scoring.
// ----------------------------------------------------------------------------
module tb_gravitational_pair_force import gpf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;  // no register behind it
  localparam int PipeDepth  = 136;
  localparam int Settle     = PipeDepth + 40;
  localparam int CycleLimit = 1_000_000;
  localparam int LongHold   = 600;                  // > pipe depth, forces a stall

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIdxW-1:0]      cfg_index = '0;
  logic [DataW-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [DataW-1:0] in_pos_a_x = '0, in_pos_a_y = '0;
  logic signed [DataW-1:0] in_pos_b_x = '0, in_pos_b_y = '0;
  logic [DataW-1:0]        in_mass_a = '0, in_mass_b = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [DataW-1:0] out_force_x, out_force_y;
  logic                    out_saturated;

  int errors, pending, forces_seen;
  int cycles = 0;
  int send_idle_pct = 0;   // chance per cycle that the sender holds back
  int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  bit long_hold_arm = 1'b0;
  int hold_left = 0;
  int pairs_sent = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  gravitational_pair_force dut (.*);

  gpf_force_checker u_chk (.*);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the pipe fills and
  // in_ready drops while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (long_hold_arm && hold_left == 0 && !out_ready && out_valid) begin
      out_ready     <= 1'b1;
      long_hold_arm <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic start_long_hold();
    @(posedge clk);
    hold_left = LongHold;
    long_hold_arm = 1'b1;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pair(input logic [DataW-1:0] ax, ay, bx, by, ma, mb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pos_a_x <= ax;
    in_pos_a_y <= ay;
    in_pos_b_x <= bx;
    in_pos_b_y <= by;
    in_mass_a  <= ma;
    in_mass_b  <= mb;
    do @(posedge clk); while (!in_ready);   // transfer at this edge
    pairs_sent++;
  endtask

  // Most pairs sit close together so the clamps and moderate magnitudes are
  // hit; the rest are full-range noise and coincident bodies.
  task automatic send_random_pair();
    logic [DataW-1:0] ax, ay, bx, by, ma, mb;
    int kind;
    kind = $urandom_range(9);
    ax = $urandom;
    ay = $urandom;
    ma = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0010_0000);
    mb = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0010_0000);
    if (kind < 3) begin
      bx = $urandom;
      by = $urandom;
    end else if (kind == 3) begin
      bx = ax;
      by = ay;
    end else begin
      bx = ax + ($urandom >>> $urandom_range(31, 8)) - 32'($urandom_range(1) << 20);
      by = ay + ($urandom >>> $urandom_range(31, 8)) - 32'($urandom_range(1) << 20);
    end
    send_pair(ax, ay, bx, by, ma, mb);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic directed_pairs();
    send_pair(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0001_0000);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, '1, '1);
    send_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0, '1, '1);
    send_pair(32'h0, 32'h0, 32'h1, 32'h0, 32'h0001_0000, 32'h0001_0000);
    send_pair(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, '1, 32'h0001_0000);
    send_pair(32'h0, 32'h0, 32'h0, 32'h0, '0, '0);
    send_pair(32'h0, 32'h0, 32'h0100_0000, 32'h0, '0, '1);
    send_pair(32'h0, 32'h0, 32'h0003_0000, 32'hFFFC_0000, 32'h0002_0000, 32'h0008_0000);
    send_pair(32'h0, 32'h0, 32'h0, 32'h0000_0100, 32'h0001_0000, 32'h0001_0000);
    send_pair(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h1, 32'h0100_0000, 32'h0100_0000);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1, 32'h1);
  endtask

  task automatic run_phase(input logic [DataW-1:0] g, dmin, dmax,
                           input int idle_pct, stall_pct, count);
    write_reg(RegGravConst, g);
    write_reg(RegMinDistSq, dmin);
    write_reg(RegMaxDistSq, dmax);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    directed_pairs();
    repeat (count) send_random_pair();
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values first, no idling
    directed_pairs();
    repeat (250) send_random_pair();
    drain();

    // stray index must leave G alone
    write_reg(RegUnused, 32'h0);
    fork
      start_long_hold();
      run_phase('1, 32'h1, '1, 0, 0, 250);
    join
    // crossed clamp bounds: lower clamp dominates
    run_phase(32'h0000_0100, '1, 32'h1, 58, 0, 250);
    // zero lower clamp, tiny offsets round to a zero distance
    run_phase(32'h0001_0000, 32'h0, 32'h0010_0000, 0, 58, 250);
    run_phase($urandom, $urandom_range(32'h0100_0000, 1), $urandom, 12, 12, 250);
    run_phase(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 58, 58, 100);

    $display("%0d pairs sent, %0d forces checked over six register settings", pairs_sent,
             forces_seen);
    $display("idle patterns: none, sender, receiver, both, plus a long receiver hold");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
